### hw/rtl/mdst_pkg.sv
// Shared types, sizes and codes of the multiway digital search tree.
package mdst_pkg;

  // Pool and link sizes.
  localparam int unsigned NODE_COUNT = 1024;
  localparam int unsigned NODE_W     = $clog2(NODE_COUNT);
  localparam int unsigned MAX_FANOUT = 16;
  localparam int unsigned SLOT_W     = $clog2(MAX_FANOUT);
  localparam int unsigned LINK_W     = NODE_W + 1;
  localparam int unsigned LADDR_W    = NODE_W + SLOT_W;
  localparam int unsigned KEY_W      = 16;
  localparam int unsigned FAN_W      = 5;
  localparam int unsigned REM_W      = 4;
  localparam int unsigned CNT_W      = NODE_W + 1;

  localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODE_COUNT - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_FANOUT - 1);

  // Configuration register indexes.
  localparam logic CFG_ROOT_FANOUT  = 1'b0;
  localparam logic CFG_CHILD_FANOUT = 1'b1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2,
    OP_SPARE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FOUND    = 3'd2,
    ST_ABSENT   = 3'd3,
    ST_DELETED  = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_KRD, S_KCHK, S_DIV, S_LRD, S_LCHK, S_POP, S_ACLR,
    S_ALINK, S_SRD, S_SCHK, S_FIN, S_LKWR, S_RKV, S_RCLR, S_OUT
  } state_e;

  // Clamp a fanout register into the legal range.
  function automatic logic [FAN_W-1:0] clamp_fanout(input logic [FAN_W-1:0] f);
    logic [FAN_W-1:0] r;
    if (f < FAN_W'(2)) begin
      r = FAN_W'(2);
    end else if (f > FAN_W'(MAX_FANOUT)) begin
      r = FAN_W'(MAX_FANOUT);
    end else begin
      r = f;
    end
    return r;
  endfunction

endpackage

### hw/rtl/mdst_div.sv
// Restoring divider of a key remainder by a small fanout, one bit per cycle.
module mdst_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mdst_pkg::KEY_W-1:0]   dividend_i,
  input  logic [mdst_pkg::FAN_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [mdst_pkg::KEY_W-1:0]   quot_o,
  output logic [mdst_pkg::REM_W-1:0]   rem_o
);

  localparam int unsigned STEP_W = $clog2(mdst_pkg::KEY_W);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [STEP_W-1:0]           cnt_q, cnt_d;
  logic [mdst_pkg::KEY_W-1:0]  quo_q, quo_d;
  logic [mdst_pkg::REM_W-1:0]  rem_q, rem_d;
  logic [mdst_pkg::FAN_W-1:0]  dvs_q, dvs_d;
  logic [mdst_pkg::FAN_W-1:0]  trial;
  logic                        fits;

  // One restoring step: bring down the next dividend bit and try the divisor.
  always_comb begin
    trial  = {rem_q, quo_q[mdst_pkg::KEY_W-1]};
    fits   = (trial >= dvs_q);
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[mdst_pkg::KEY_W-2:0], fits};
      rem_d = fits ? mdst_pkg::REM_W'(trial - dvs_q) : mdst_pkg::REM_W'(trial);
      cnt_d = cnt_q + STEP_W'(1);
      if (cnt_q == STEP_W'(mdst_pkg::KEY_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

### hw/rtl/multiway_digital_search_tree_top.sv
// Top level of the multiway digital search tree: sequencer, node memories and free list.
// Each word walks the tree one level at a time; a level reads the node key, steps the
// bit-serial divider and reads the link. Delete adds a scan of the link slots on the way
// to the leftmost leaf and a pass that frees a node.
// One word is in work at a time; the result word waits in an output register.
// After reset a pass clears the root links; no word is accepted meanwhile.
module multiway_digital_search_tree_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  in_op_i,
  input  logic [mdst_pkg::KEY_W-1:0]  in_key_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  out_status_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [mdst_pkg::FAN_W-1:0]  cfg_data_i
);

  localparam int unsigned NW = mdst_pkg::NODE_W;
  localparam int unsigned SW = mdst_pkg::SLOT_W;
  localparam int unsigned LW = mdst_pkg::LINK_W;
  localparam int unsigned AW = mdst_pkg::LADDR_W;
  localparam int unsigned KW = mdst_pkg::KEY_W;
  localparam int unsigned CW = mdst_pkg::CNT_W;

  mdst_pkg::state_e  state_q, state_d;

  // Memories: key plus valid flag per node, child links, free node stack.
  logic [KW:0]   key_mem  [mdst_pkg::NODE_COUNT];
  logic [LW-1:0] link_mem [mdst_pkg::NODE_COUNT * mdst_pkg::MAX_FANOUT];
  logic [NW-1:0] free_mem [mdst_pkg::NODE_COUNT];

  logic          km_we;
  logic [NW-1:0] km_addr;
  logic [KW:0]   km_wdata, km_rdata_q;
  logic          lm_we;
  logic [AW-1:0] lm_addr;
  logic [LW-1:0] lm_wdata, lm_rdata_q;
  logic          fl_we;
  logic [NW-1:0] fl_addr;
  logic [NW-1:0] fl_wdata, fl_rdata_q;

  logic [mdst_pkg::FAN_W-1:0] root_fan_q, child_fan_q;
  logic          root_valid_q, root_valid_d;
  logic [1:0]    op_q, op_d;
  logic [KW-1:0] key_q, key_d;
  logic [KW-1:0] rem_q, rem_d;
  logic [NW-1:0] cur_q, cur_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [AW-1:0] pidx_q, pidx_d;
  logic [NW-1:0] leaf_q, leaf_d;
  logic [AW-1:0] lidx_q, lidx_d;
  logic [NW-1:0] steps_q, steps_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] fcnt_q, fcnt_d;
  logic [CW-1:0] low_q, low_d;
  logic [NW-1:0] popi_q, popi_d;
  logic [NW-1:0] nn_q, nn_d;
  logic [NW-1:0] rel_q, rel_d;
  logic [2:0]    status_q, status_d;
  logic          out_valid_q, out_valid_d;
  logic [2:0]    out_status_q, out_status_d;

  logic          div_start, div_done;
  logic [KW-1:0] div_quot;
  logic [mdst_pkg::REM_W-1:0] div_rem;
  logic [mdst_pkg::FAN_W-1:0] fanout;

  logic          in_acc, out_free;
  logic          kvalid, kmatch, link_nz;
  logic [NW-1:0] link_node;

  assign in_acc    = in_valid_i && (state_q == mdst_pkg::S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign kvalid    = (cur_q == '0) ? root_valid_q : km_rdata_q[KW];
  assign kmatch    = (km_rdata_q[KW-1:0] == key_q);
  assign link_nz   = (lm_rdata_q != '0);
  assign link_node = NW'(lm_rdata_q - LW'(1));
  assign fanout    = (cur_q == '0) ? mdst_pkg::clamp_fanout(root_fan_q)
                                   : mdst_pkg::clamp_fanout(child_fan_q);

  mdst_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rem_q),
    .divisor_i  (fanout),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mdst_pkg::S_INIT: if (cnt_q == mdst_pkg::SLOT_LAST) state_d = mdst_pkg::S_IDLE;
      mdst_pkg::S_IDLE: if (in_acc) state_d = mdst_pkg::S_KRD;
      mdst_pkg::S_KRD:  state_d = mdst_pkg::S_KCHK;
      mdst_pkg::S_KCHK: begin
        if (op_q == mdst_pkg::OP_INSERT) begin
          state_d = (!kvalid || kmatch) ? mdst_pkg::S_OUT : mdst_pkg::S_DIV;
        end else if (kvalid && kmatch) begin
          state_d = (op_q == mdst_pkg::OP_DELETE) ? mdst_pkg::S_SRD : mdst_pkg::S_OUT;
        end else begin
          state_d = mdst_pkg::S_DIV;
        end
      end
      mdst_pkg::S_DIV:  if (div_done) state_d = mdst_pkg::S_LRD;
      mdst_pkg::S_LRD:  state_d = mdst_pkg::S_LCHK;
      mdst_pkg::S_LCHK: begin
        if (link_nz) begin
          state_d = (steps_q == mdst_pkg::NODE_LAST) ? mdst_pkg::S_OUT : mdst_pkg::S_KRD;
        end else if (op_q == mdst_pkg::OP_INSERT && fcnt_q != '0) begin
          state_d = mdst_pkg::S_POP;
        end else begin
          state_d = mdst_pkg::S_OUT;
        end
      end
      mdst_pkg::S_POP:  state_d = mdst_pkg::S_ACLR;
      mdst_pkg::S_ACLR: if (cnt_q == mdst_pkg::SLOT_LAST) state_d = mdst_pkg::S_ALINK;
      mdst_pkg::S_ALINK: state_d = mdst_pkg::S_OUT;
      mdst_pkg::S_SRD:  state_d = mdst_pkg::S_SCHK;
      mdst_pkg::S_SCHK: begin
        if (link_nz) begin
          state_d = (steps_q == mdst_pkg::NODE_LAST) ? mdst_pkg::S_FIN : mdst_pkg::S_SRD;
        end else begin
          state_d = (cnt_q == mdst_pkg::SLOT_LAST) ? mdst_pkg::S_FIN : mdst_pkg::S_SRD;
        end
      end
      mdst_pkg::S_FIN:  state_d = (leaf_q == cur_q) ? mdst_pkg::S_RKV : mdst_pkg::S_LKWR;
      mdst_pkg::S_LKWR: state_d = mdst_pkg::S_RKV;
      mdst_pkg::S_RKV:  state_d = mdst_pkg::S_RCLR;
      mdst_pkg::S_RCLR: if (cnt_q == mdst_pkg::SLOT_LAST) state_d = mdst_pkg::S_OUT;
      mdst_pkg::S_OUT:  if (out_free) state_d = mdst_pkg::S_IDLE;
      default:          state_d = mdst_pkg::S_IDLE;
    endcase
  end

  // Datapath updates and memory port controls per state.
  always_comb begin
    root_valid_d = root_valid_q;
    op_d     = op_q;
    key_d    = key_q;
    rem_d    = rem_q;
    cur_d    = cur_q;
    slot_d   = slot_q;
    pidx_d   = pidx_q;
    leaf_d   = leaf_q;
    lidx_d   = lidx_q;
    steps_d  = steps_q;
    cnt_d    = cnt_q;
    fcnt_d   = fcnt_q;
    low_d    = low_q;
    popi_d   = popi_q;
    nn_d     = nn_q;
    rel_d    = rel_q;
    status_d = status_q;
    div_start = 1'b0;
    km_we    = 1'b0;
    km_addr  = cur_q;
    km_wdata = {1'b1, key_q};
    lm_we    = 1'b0;
    lm_addr  = {cur_q, slot_q};
    lm_wdata = '0;
    fl_we    = 1'b0;
    fl_addr  = NW'(fcnt_q - CW'(1));
    fl_wdata = rel_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    unique case (state_q)
      mdst_pkg::S_INIT: begin
        lm_we   = 1'b1;
        lm_addr = {NW'(0), cnt_q};
        cnt_d   = cnt_q + SW'(1);
      end
      mdst_pkg::S_IDLE: begin
        op_d    = in_op_i;
        key_d   = in_key_i;
        rem_d   = in_key_i;
        cur_d   = '0;
        pidx_d  = '0;
        steps_d = '0;
      end
      mdst_pkg::S_KRD: ;
      mdst_pkg::S_KCHK: begin
        if (op_q == mdst_pkg::OP_INSERT) begin
          if (!kvalid) begin
            km_we    = 1'b1;
            status_d = mdst_pkg::ST_INSERTED;
            if (cur_q == '0) root_valid_d = 1'b1;
          end else if (kmatch) begin
            status_d = mdst_pkg::ST_PRESENT;
          end else begin
            div_start = 1'b1;
          end
        end else if (kvalid && kmatch) begin
          status_d = mdst_pkg::ST_FOUND;
          leaf_d   = cur_q;
          lidx_d   = pidx_q;
          steps_d  = '0;
          cnt_d    = '0;
        end else begin
          div_start = 1'b1;
        end
      end
      mdst_pkg::S_DIV: begin
        if (div_done) begin
          slot_d = div_rem;
          rem_d  = div_quot;
        end
      end
      mdst_pkg::S_LRD: ;
      mdst_pkg::S_LCHK: begin
        if (link_nz) begin
          pidx_d  = {cur_q, slot_q};
          cur_d   = link_node;
          steps_d = steps_q + NW'(1);
          status_d = (op_q == mdst_pkg::OP_INSERT) ? mdst_pkg::ST_FULL : mdst_pkg::ST_ABSENT;
        end else if (op_q == mdst_pkg::OP_INSERT) begin
          status_d = mdst_pkg::ST_FULL;
          popi_d   = NW'(fcnt_q - CW'(1));
        end else begin
          status_d = mdst_pkg::ST_ABSENT;
        end
      end
      mdst_pkg::S_POP: begin
        // Stack entries below the lowest fill ever reached were never written; their node is computed.
        nn_d   = ({1'b0, popi_q} < low_q) ? (mdst_pkg::NODE_LAST - popi_q) : fl_rdata_q;
        fcnt_d = fcnt_q - CW'(1);
        if ({1'b0, popi_q} < low_q) low_d = {1'b0, popi_q};
        cnt_d  = '0;
      end
      mdst_pkg::S_ACLR: begin
        lm_we   = 1'b1;
        lm_addr = {nn_q, cnt_q};
        cnt_d   = cnt_q + SW'(1);
      end
      mdst_pkg::S_ALINK: begin
        lm_we    = 1'b1;
        lm_wdata = {1'b0, nn_q} + LW'(1);
        km_we    = 1'b1;
        km_addr  = nn_q;
        status_d = mdst_pkg::ST_INSERTED;
      end
      mdst_pkg::S_SRD: begin
        lm_addr = {leaf_q, cnt_q};
      end
      mdst_pkg::S_SCHK: begin
        if (link_nz) begin
          leaf_d  = link_node;
          lidx_d  = {leaf_q, cnt_q};
          steps_d = steps_q + NW'(1);
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + SW'(1);
        end
      end
      mdst_pkg::S_FIN: begin
        // A matched leaf is unlinked itself; otherwise fetch the leaf key first.
        km_addr = leaf_q;
        rel_d   = leaf_q;
        if (leaf_q == cur_q && cur_q != '0) begin
          lm_we   = 1'b1;
          lm_addr = pidx_q;
        end
      end
      mdst_pkg::S_LKWR: begin
        km_we    = 1'b1;
        km_wdata = {1'b1, km_rdata_q[KW-1:0]};
        lm_we    = 1'b1;
        lm_addr  = lidx_q;
      end
      mdst_pkg::S_RKV: begin
        km_we    = 1'b1;
        km_addr  = rel_q;
        km_wdata = '0;
        if (rel_q == '0) root_valid_d = 1'b0;
        cnt_d    = '0;
      end
      mdst_pkg::S_RCLR: begin
        lm_we   = 1'b1;
        lm_addr = {rel_q, cnt_q};
        cnt_d   = cnt_q + SW'(1);
        status_d = mdst_pkg::ST_DELETED;
        if (cnt_q == mdst_pkg::SLOT_LAST && rel_q != '0 &&
            fcnt_q < CW'(mdst_pkg::NODE_COUNT)) begin
          fl_we   = 1'b1;
          fl_addr = NW'(fcnt_q);
          fcnt_d  = fcnt_q + CW'(1);
        end
      end
      mdst_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
        end
      end
      default: ;
    endcase
  end

  // Memory ports with registered read data.
  always_ff @(posedge clk_i) begin
    if (km_we) key_mem[km_addr] <= km_wdata;
    km_rdata_q <= key_mem[km_addr];
  end

  always_ff @(posedge clk_i) begin
    if (lm_we) link_mem[lm_addr] <= lm_wdata;
    lm_rdata_q <= link_mem[lm_addr];
  end

  always_ff @(posedge clk_i) begin
    if (fl_we) free_mem[fl_addr] <= fl_wdata;
    fl_rdata_q <= free_mem[fl_addr];
  end

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mdst_pkg::S_INIT;
      root_valid_q <= 1'b0;
      cnt_q        <= '0;
      steps_q      <= '0;
      fcnt_q       <= CW'(mdst_pkg::NODE_COUNT - 1);
      low_q        <= CW'(mdst_pkg::NODE_COUNT - 1);
      out_valid_q  <= 1'b0;
      root_fan_q   <= mdst_pkg::FAN_W'(16);
      child_fan_q  <= mdst_pkg::FAN_W'(2);
    end else begin
      state_q      <= state_d;
      root_valid_q <= root_valid_d;
      cnt_q        <= cnt_d;
      steps_q      <= steps_d;
      fcnt_q       <= fcnt_d;
      low_q        <= low_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i && cfg_idx_i == mdst_pkg::CFG_ROOT_FANOUT) root_fan_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == mdst_pkg::CFG_CHILD_FANOUT) child_fan_q <= cfg_data_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    rem_q        <= rem_d;
    cur_q        <= cur_d;
    slot_q       <= slot_d;
    pidx_q       <= pidx_d;
    leaf_q       <= leaf_d;
    lidx_q       <= lidx_d;
    popi_q       <= popi_d;
    nn_q         <= nn_d;
    rel_q        <= rel_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
  end

  assign in_stall_o   = (state_q != mdst_pkg::S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;

  // A result word only appears when the sequencer hands one over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == mdst_pkg::S_OUT))
    else $error("result word without a finished walk");

  // An accepted word starts its walk at the root.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == mdst_pkg::S_KRD && cur_q == '0))
    else $error("walk did not start at the root");

  // The free stack never drops below its lowest recorded fill.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_q <= fcnt_q)
    else $error("free stack fill below its low mark");

endmodule

### test/multiway_digital_search_tree_top_test.sv
// Self-checking testbench for the multiway digital search tree top level.
`timescale 1ns / 100ps

module multiway_digital_search_tree_top_test;

  localparam int unsigned CYCLE_LIMIT = 10000000;

  // Shadow tree that predicts the status word of every operation.
  class tree_scoreboard;
    logic [mdst_pkg::KEY_W-1:0] node_key [mdst_pkg::NODE_COUNT];
    bit               node_used [mdst_pkg::NODE_COUNT];
    int unsigned      links [mdst_pkg::NODE_COUNT*mdst_pkg::MAX_FANOUT];
    int unsigned      free_nodes [mdst_pkg::NODE_COUNT];
    int unsigned      free_count;
    int unsigned      root_fan;
    int unsigned      child_fan;
    mdst_pkg::status_e pending [$];
    int unsigned      mismatches;

    function new();
      for (int i = 0; i < mdst_pkg::NODE_COUNT; i++) begin
        node_key[i] = '0;
        node_used[i] = 1'b0;
      end
      for (int i = 0; i < mdst_pkg::NODE_COUNT*mdst_pkg::MAX_FANOUT; i++) links[i] = 0;
      free_count = 0;
      for (int i = mdst_pkg::NODE_COUNT - 1; i >= 1; i--) begin
        free_nodes[free_count] = i;
        free_count++;
      end
      root_fan = 16;
      child_fan = 2;
      mismatches = 0;
    endfunction

    function void write_reg(logic idx, logic [mdst_pkg::FAN_W-1:0] value);
      if (idx == mdst_pkg::CFG_ROOT_FANOUT) root_fan = value;
      else child_fan = value;
    endfunction

    function int unsigned fanout(int unsigned node);
      int unsigned f;
      f = (node == 0) ? root_fan : child_fan;
      if (f < 2) f = 2;
      if (f > mdst_pkg::MAX_FANOUT) f = mdst_pkg::MAX_FANOUT;
      return f;
    endfunction

    function void free_node(int unsigned node);
      node_used[node] = 1'b0;
      for (int s = 0; s < mdst_pkg::MAX_FANOUT; s++) links[node*mdst_pkg::MAX_FANOUT + s] = 0;
      if (node != 0 && free_count < mdst_pkg::NODE_COUNT) begin
        free_nodes[free_count] = node;
        free_count++;
      end
    endfunction

    function mdst_pkg::status_e insert_key(logic [mdst_pkg::KEY_W-1:0] k);
      int unsigned cur, rem, f, idx, nn;
      cur = 0;
      rem = k;
      for (int step = 0; step < mdst_pkg::NODE_COUNT; step++) begin
        if (!node_used[cur]) begin
          node_key[cur] = k;
          node_used[cur] = 1'b1;
          return mdst_pkg::ST_INSERTED;
        end
        if (node_key[cur] == k) return mdst_pkg::ST_PRESENT;
        f = fanout(cur);
        idx = cur*mdst_pkg::MAX_FANOUT + rem % f;
        rem = rem / f;
        if (links[idx] == 0) begin
          if (free_count == 0) return mdst_pkg::ST_FULL;
          free_count--;
          nn = free_nodes[free_count];
          for (int s = 0; s < mdst_pkg::MAX_FANOUT; s++) links[nn*mdst_pkg::MAX_FANOUT + s] = 0;
          node_key[nn] = k;
          node_used[nn] = 1'b1;
          links[idx] = nn + 1;
          return mdst_pkg::ST_INSERTED;
        end
        cur = links[idx] - 1;
      end
      return mdst_pkg::ST_FULL;
    endfunction

    function mdst_pkg::status_e find_key(logic [mdst_pkg::KEY_W-1:0] k, bit remove);
      int unsigned cur, rem, f, idx, parent_idx, leaf, leaf_idx, next;
      cur = 0;
      rem = k;
      parent_idx = 0;
      for (int step = 0; step < mdst_pkg::NODE_COUNT; step++) begin
        if (node_used[cur] && node_key[cur] == k) begin
          if (!remove) return mdst_pkg::ST_FOUND;
          leaf = cur;
          leaf_idx = parent_idx;
          // Descend through the first occupied slot down to a true leaf.
          for (int d = 0; d < mdst_pkg::NODE_COUNT; d++) begin
            next = 0;
            for (int s = 0; s < mdst_pkg::MAX_FANOUT; s++) begin
              if (next == 0 && links[leaf*mdst_pkg::MAX_FANOUT + s] != 0) begin
                next = links[leaf*mdst_pkg::MAX_FANOUT + s];
                leaf_idx = leaf*mdst_pkg::MAX_FANOUT + s;
              end
            end
            if (next == 0) break;
            leaf = next - 1;
          end
          if (leaf == cur) begin
            if (cur != 0) links[parent_idx] = 0;
            free_node(cur);
          end else begin
            node_key[cur] = node_key[leaf];
            links[leaf_idx] = 0;
            free_node(leaf);
          end
          return mdst_pkg::ST_DELETED;
        end
        f = fanout(cur);
        idx = cur*mdst_pkg::MAX_FANOUT + rem % f;
        rem = rem / f;
        if (links[idx] == 0) return mdst_pkg::ST_ABSENT;
        parent_idx = idx;
        cur = links[idx] - 1;
      end
      return mdst_pkg::ST_ABSENT;
    endfunction

    function void note_word(logic [1:0] op, logic [mdst_pkg::KEY_W-1:0] k);
      mdst_pkg::status_e st;
      if (op == mdst_pkg::OP_INSERT) st = insert_key(k);
      else if (op == mdst_pkg::OP_DELETE) st = find_key(k, 1'b1);
      else st = find_key(k, 1'b0);
      pending.push_back(st);
    endfunction

    function void check_word(logic [2:0] got);
      mdst_pkg::status_e want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: status %0d", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("status mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [1:0]       in_op_i;
  logic [mdst_pkg::KEY_W-1:0] in_key_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [2:0]       out_status_o;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [mdst_pkg::FAN_W-1:0] cfg_data_i;

  tree_scoreboard tree_sb;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  int unsigned    cycle_count;
  logic [mdst_pkg::KEY_W-1:0] key_pool [$];

  multiway_digital_search_tree_top uut (.*);

  // Clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Receiver: check accepted result words and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tree_sb.check_word(out_status_o);
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("multiway_digital_search_tree_top: mismatch");
      $finish;
    end
  end

  // Drive one word and wait until the block accepts it; valid drops only while idling.
  task automatic send_word(logic [1:0] op, logic [mdst_pkg::KEY_W-1:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_op_i <= op;
    in_key_i <= k;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tree_sb.note_word(op, k);
  endtask

  // Write one fanout register once all results are in.
  task automatic write_fanout(logic idx, logic [mdst_pkg::FAN_W-1:0] value);
    in_valid_i <= 1'b0;
    while (tree_sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tree_sb.write_reg(idx, value);
  endtask

  // Random word, mostly on keys already used so deletes and lookups hit.
  task automatic send_random();
    logic [1:0]       op;
    logic [mdst_pkg::KEY_W-1:0] k;
    int unsigned      pick;
    pick = $urandom_range(99);
    if (pick < 45) op = mdst_pkg::OP_INSERT;
    else if (pick < 70) op = mdst_pkg::OP_LOOKUP;
    else if (pick < 97) op = mdst_pkg::OP_DELETE;
    else op = mdst_pkg::OP_SPARE;
    if (key_pool.size() != 0 && $urandom_range(99) < 55) begin
      k = key_pool[$urandom_range(key_pool.size() - 1)];
    end else if ($urandom_range(3) == 0) begin
      k = mdst_pkg::KEY_W'($urandom_range(63));
    end else begin
      k = mdst_pkg::KEY_W'($urandom);
    end
    if (op == mdst_pkg::OP_INSERT && key_pool.size() < 400) key_pool.push_back(k);
    send_word(op, k);
  endtask

  initial begin
    tree_sb = new();
    cycle_count = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_op_i = mdst_pkg::OP_INSERT;
    in_key_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = mdst_pkg::CFG_ROOT_FANOUT;
    cfg_data_i = '0;
    send_idle_pct = 26;
    recv_idle_pct = 81;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every operation, spare code and delete paths.
    send_word(mdst_pkg::OP_LOOKUP, 16'h0000);
    send_word(mdst_pkg::OP_DELETE, 16'hFFFF);
    send_word(mdst_pkg::OP_INSERT, 16'h0000);
    send_word(mdst_pkg::OP_INSERT, 16'h0000);
    send_word(mdst_pkg::OP_INSERT, 16'hFFFF);
    send_word(mdst_pkg::OP_INSERT, 16'h5555);
    send_word(mdst_pkg::OP_INSERT, 16'hAAAA);
    send_word(mdst_pkg::OP_INSERT, 16'h00FF);
    send_word(mdst_pkg::OP_INSERT, 16'h01FF);
    send_word(mdst_pkg::OP_LOOKUP, 16'hFFFF);
    send_word(mdst_pkg::OP_SPARE, 16'h5555);
    send_word(mdst_pkg::OP_SPARE, 16'h1234);
    send_word(mdst_pkg::OP_DELETE, 16'h0000);
    send_word(mdst_pkg::OP_DELETE, 16'h00FF);
    send_word(mdst_pkg::OP_LOOKUP, 16'h01FF);
    send_word(mdst_pkg::OP_DELETE, 16'h1234);
    write_fanout(mdst_pkg::CFG_ROOT_FANOUT, 5'd0);
    write_fanout(mdst_pkg::CFG_CHILD_FANOUT, 5'd31);
    send_word(mdst_pkg::OP_LOOKUP, 16'hAAAA);
    send_word(mdst_pkg::OP_INSERT, 16'h8001);
    send_word(mdst_pkg::OP_DELETE, 16'hFFFF);

    // Random phases under changing fanouts and idling patterns.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_fanout(mdst_pkg::CFG_ROOT_FANOUT, 5'd2);
          write_fanout(mdst_pkg::CFG_CHILD_FANOUT, 5'd2);
        end
        1: begin
          write_fanout(mdst_pkg::CFG_ROOT_FANOUT, 5'd16);
          write_fanout(mdst_pkg::CFG_CHILD_FANOUT, 5'd16);
        end
        2: begin
          write_fanout(mdst_pkg::CFG_ROOT_FANOUT, 5'd1);
          write_fanout(mdst_pkg::CFG_CHILD_FANOUT, 5'd17);
        end
        default: begin
          write_fanout(mdst_pkg::CFG_ROOT_FANOUT, mdst_pkg::FAN_W'($urandom));
          write_fanout(mdst_pkg::CFG_CHILD_FANOUT, mdst_pkg::FAN_W'($urandom_range(2, 16)));
        end
      endcase
      key_pool.delete();
      send_idle_pct = (phase < 2) ? 26 : (phase < 4) ? 81 : 0;
      recv_idle_pct = (phase < 2) ? 81 : (phase < 4) ? 26 : 0;
      for (int i = 0; i < 65; i++) send_random();
    end

    // Fill the pool with distinct new keys under a narrow tree.
    write_fanout(mdst_pkg::CFG_ROOT_FANOUT, 5'd2);
    write_fanout(mdst_pkg::CFG_CHILD_FANOUT, 5'd2);
    for (int i = 0; i < 1100; i++) send_word(mdst_pkg::OP_INSERT, mdst_pkg::KEY_W'(i * 37 + 5));
    for (int i = 0; i < 40; i++) send_word(mdst_pkg::OP_DELETE, mdst_pkg::KEY_W'(i * 37 + 5));
    send_word(mdst_pkg::OP_INSERT, 16'hFFFE);
    in_valid_i <= 1'b0;

    while (tree_sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (tree_sb.mismatches == 0) begin
      $display("multiway_digital_search_tree_top: match");
    end else begin
      $display("multiway_digital_search_tree_top: mismatch");
    end
    $finish;
  end

endmodule
